// File: rtl/stp_pkg.sv
`default_nettype none
package stp_pkg;

   localparam int SLOTS      = 8;
   localparam int COUNT_BITS = 16;
   localparam int TAG_BITS   = 16;
   localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);

   localparam logic [CNT_W-1:0]      CNT_FULL = CNT_W'(SLOTS);
   localparam logic [CNT_W-1:0]      CNT_ONE  = CNT_W'(1);
   localparam logic [IDX_BITS-1:0]   IDX_ONE  = IDX_BITS'(1);
   localparam logic [COUNT_BITS-1:0] TICK_ONE = COUNT_BITS'(1);

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   typedef struct packed {
      logic [COUNT_BITS-1:0] ticks;
      logic [TAG_BITS-1:0]   tag;
   } entry_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
   } mem_req_type;

   typedef struct packed {
      logic                expired;
      logic [TAG_BITS-1:0] expired_tag;
      logic                pool_full;
      logic                cancel_found;
   } rsp_word_type;

   // widen or trim a 16-bit start count to the counter width
   function automatic logic [COUNT_BITS-1:0] to_count(input logic [15:0] v);
      logic [COUNT_BITS+15:0] w;
      w = {{COUNT_BITS{1'b0}}, v};
      return w[COUNT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/stp_ifaces.sv
`default_nettype none
interface stp_req_if import stp_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] tick_count;
   logic [15:0] timer_tag;

   modport source (output valid, output mode, output tick_count, output timer_tag,
                   input ready);
   modport sink (input valid, input mode, input tick_count, input timer_tag,
                 output ready);
endinterface

interface stp_rsp_if import stp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                expired;
   logic [TAG_BITS-1:0] expired_tag;
   logic                pool_full;
   logic                cancel_found;

   modport source (output valid, output expired, output expired_tag,
                   output pool_full, output cancel_found, input ready);
   modport sink (input valid, input expired, input expired_tag,
                 input pool_full, input cancel_found, output ready);
endinterface
`default_nettype wire

// File: rtl/stp_store.sv
`default_nettype none
module stp_store import stp_pkg::*; (
   input  logic        clock,
   input  mem_req_type mreq,
   output entry_type   rd_data
);

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   // read and write never target the same entry in one cycle
   always_ff @(posedge clock) begin
      if (mreq.wr_en) begin
         mem[mreq.wr_addr] <= mreq.wr_data;
      end
      if (mreq.rd_en) begin
         rd_data_ff <= mem[mreq.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/stp_out.sv
`default_nettype none
module stp_out import stp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         push_ready,
   stp_rsp_if.source    rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign push_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push && push_ready) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push && push_ready) begin
         word_ff <= push_word;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.expired      = word_ff.expired;
   assign rsp_chan.expired_tag  = word_ff.expired_tag;
   assign rsp_chan.pool_full    = word_ff.pool_full;
   assign rsp_chan.cancel_found = word_ff.cancel_found;

endmodule
`default_nettype wire

// File: rtl/stp_ctrl.sv
`default_nettype none
module stp_ctrl import stp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   stp_req_if.sink      req_chan,
   output mem_req_type  mreq,
   input  entry_type    rd_data,
   output logic         push,
   output rsp_word_type push_word,
   input  logic         push_ready
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [1:0]          mode_ff, mode_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [CNT_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [IDX_BITS-1:0] chk_ptr_ff, chk_ptr_in;
   logic                pend_ff, pend_in;
   rsp_word_type        word_ff, word_in;
   logic                issue;
   logic [COUNT_BITS-1:0] dec;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign push           = (state_ff == S_DONE);
   assign push_word      = word_ff;
   assign issue          = (rd_ptr_ff < count_ff);
   assign dec            = rd_data.ticks - TICK_ONE;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      mode_in    = mode_ff;
      tag_in     = tag_ff;
      rd_ptr_in  = rd_ptr_ff;
      chk_ptr_in = chk_ptr_ff;
      pend_in    = 1'b0;
      word_in    = word_ff;
      mreq       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               word_in   = '0;
               mode_in   = req_chan.mode;
               tag_in    = req_chan.timer_tag;
               rd_ptr_in = '0;
               state_in  = S_DONE;
               if (req_chan.mode == MODE_TICK || req_chan.mode == MODE_CANCEL) begin
                  state_in = S_SCAN;
               end else if (req_chan.mode == MODE_START) begin
                  if (count_ff == CNT_FULL) begin
                     word_in.pool_full = 1'b1;
                  end else begin
                     mreq.wr_en         = 1'b1;
                     mreq.wr_addr       = count_ff[IDX_BITS-1:0];
                     mreq.wr_data.ticks = to_count(req_chan.tick_count);
                     mreq.wr_data.tag   = req_chan.timer_tag;
                     count_in           = count_ff + CNT_ONE;
                  end
               end
            end
         end
         S_SCAN, S_SHIFT: begin
            // stream reads one entry per cycle; read data is registered and returns in the following cycle
            if (issue) begin
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = rd_ptr_ff[IDX_BITS-1:0];
               rd_ptr_in    = rd_ptr_ff + CNT_ONE;
               chk_ptr_in   = rd_ptr_ff[IDX_BITS-1:0];
               pend_in      = 1'b1;
            end
            if (state_ff == S_SCAN) begin
               if (pend_ff) begin
                  if (mode_ff == MODE_TICK) begin
                     mreq.wr_en         = 1'b1;
                     mreq.wr_addr       = chk_ptr_ff;
                     mreq.wr_data.ticks = dec;
                     mreq.wr_data.tag   = rd_data.tag;
                     if (dec == '0) begin
                        word_in.expired     = 1'b1;
                        word_in.expired_tag = rd_data.tag;
                        state_in            = S_SHIFT;
                     end
                  end else if (rd_data.tag == tag_ff) begin
                     word_in.cancel_found = 1'b1;
                     state_in             = S_SHIFT;
                  end
               end else if (!issue) begin
                  state_in = S_DONE;
               end
            end else begin
               if (pend_ff) begin
                  mreq.wr_en   = 1'b1;
                  mreq.wr_addr = chk_ptr_ff - IDX_ONE;
                  mreq.wr_data = rd_data;
               end else if (!issue) begin
                  count_in = count_ff - CNT_ONE;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      mode_ff    <= mode_in;
      tag_ff     <= tag_in;
      rd_ptr_ff  <= rd_ptr_in;
      chk_ptr_ff <= chk_ptr_in;
      word_ff    <= word_in;
   end

endmodule
`default_nettype wire

// File: rtl/software_timer_pool_unit.sv
// Start or unused mode go straight to the done state and then load the output register;
// tick and cancel first walk the pool through the single memory read port, one entry
// per cycle through scan and gap-closing shift.
// One word is handled at a time, with a return to idle after each; a new word is taken
// while a result waits. Reset (synchronous, active high) empties the pool and the
// output register; timer memory contents are not cleared.
`default_nettype none
module software_timer_pool_unit import stp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   stp_req_if.sink   req_chan,
   stp_rsp_if.source rsp_chan
);

   mem_req_type  mreq;
   entry_type    rd_data;
   logic         push;
   logic         push_ready;
   rsp_word_type push_word;

   // sequencer: scan, modify and write back, then close the gap on a removal
   stp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .mreq       (mreq),
      .rd_data    (rd_data),
      .push       (push),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   // timer store: ticks and tag per slot, oldest timer at slot zero
   stp_store u_store (
      .clock   (clock),
      .mreq    (mreq),
      .rd_data (rd_data)
   );

   // hold the finished word so the sequencer can take the next one
   stp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .push_ready (push_ready),
      .rsp_chan   (rsp_chan)
   );

   // a write never lands on the entry being read in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mreq.wr_en && mreq.rd_en && (mreq.wr_addr == mreq.rd_addr)))
      else $error("memory read and write hit the same entry");

   // at most one outcome flag per result word
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      push |-> ($countones({push_word.expired, push_word.pool_full,
                            push_word.cancel_found}) <= 1))
      else $error("result word carries more than one outcome");

   // expired tag is zero unless a timer expired
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (push && !push_word.expired) |-> (push_word.expired_tag == '0))
      else $error("expired tag set without expiry");

   // sequencer is busy in the cycle after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("sequencer ready right after accepting a word");

endmodule
`default_nettype wire
